// ===== src/tijm_pkg.sv =====
// Package: shared types and constants of the transmit interval jitter monitor.
package tijm_pkg;

    localparam int LOG_DEPTH_DEF = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_NOTE_TX    = 2'd0,
        CMD_END_PERIOD = 2'd1,
        CMD_RESET_MEAS = 2'd2,
        CMD_READ_LOG   = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_PRIMED    = 3'd1;
    localparam logic [2:0] ST_BACKWARDS = 3'd2;
    localparam logic [2:0] ST_IN_RANGE  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_TOO_SHORT = 3'd5;
    localparam logic [2:0] ST_LOG_FULL  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq_num;
        logic [31:0] timestamp;
        logic [3:0]  log_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] interval;
        logic [31:0] min_interval;
        logic [31:0] max_interval;
        logic [31:0] average_interval;
        logic [31:0] packets_in_period;
        logic [31:0] window_first_sequence;
        logic [31:0] window_sequence_span;
        logic [4:0]  violation_count;
        logic [31:0] log_sequence;
        logic [31:0] log_interval;
        logic [31:0] log_time;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic exec;       // run the command held in the input register
        logic div_start;  // load the divider
        logic div_step;   // one restoring step
        logic div_done;   // write the quotient to the snapshot
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic is_end_period;
    } t_stat;

endpackage

// ===== src/tijm_stream_if.sv =====
// Interface: valid/ready channel carrying one item per beat.
interface tijm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tijm_ctrl.sv =====
// Controller: sequences each command and the bit-serial division.
module tijm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tijm_pkg::t_stat  i_stat,
    output tijm_pkg::t_ctrl  o_ctrl
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_OUT} t_state;

    t_state     r_state;
    logic [6:0] r_cnt;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctrl.exec      = (r_state == S_EXEC) && !i_stat.is_end_period;
        o_ctrl.div_start = (r_state == S_EXEC) && i_stat.is_end_period;
        o_ctrl.div_step  = (r_state == S_DIV) && (r_cnt != 7'd64);
        o_ctrl.div_done  = (r_state == S_DIV) && (r_cnt == 7'd64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_cnt <= '0;
                    r_state <= i_stat.is_end_period ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (r_cnt == 7'd64) r_state <= S_OUT;
                    else r_cnt <= r_cnt + 7'd1;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/tijm_datapath.sv =====
// Datapath: statistics registers, violation log, limit compare and divider.
module tijm_datapath #(
    parameter int LOG_DEPTH = tijm_pkg::LOG_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_fire,
    input  tijm_pkg::t_in_item               i_in,
    input  logic                             i_cfg_we,
    input  logic [tijm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tijm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  tijm_pkg::t_ctrl                  i_ctrl,
    output tijm_pkg::t_stat                  o_stat,
    output tijm_pkg::t_out_item              o_out
);
    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);

    logic [31:0] r_upper, r_lower;
    tijm_pkg::t_in_item r_in;

    logic [31:0] r_prev_time, r_pkt_cnt, r_min, r_max, r_samples;
    logic [63:0] r_sum;
    logic [31:0] r_latest_seq, r_start_seq;
    logic [31:0] r_snap_avg, r_snap_pkts, r_snap_span, r_snap_first;
    logic [CW-1:0] r_logged;

    logic [31:0] r_mem_seq  [LOG_DEPTH];
    logic [31:0] r_mem_ival [LOG_DEPTH];
    logic [31:0] r_mem_time [LOG_DEPTH];
    logic [31:0] r_rd_seq, r_rd_ival, r_rd_time;
    logic        r_rd_ok;

    // divider
    logic [63:0] r_quot;
    logic [32:0] r_rem;
    logic [32:0] n_rem_sh;

    logic [2:0]  r_status;
    logic [31:0] r_ival;

    // note_tx decisions
    logic [31:0] n_pkt_cnt, n_d;
    logic        n_prime, n_back, n_long, n_short, n_out, n_full;
    logic [AW-1:0] n_wr_addr;

    assign o_stat.is_end_period = (r_in.command == tijm_pkg::CMD_END_PERIOD);

    always_comb begin
        n_pkt_cnt = r_pkt_cnt + 32'd1;
        n_prime   = (n_pkt_cnt == 32'd1) && (r_prev_time == '0);
        n_back    = r_in.timestamp < r_prev_time;
        n_d       = r_in.timestamp - r_prev_time;
        n_long    = n_d > r_upper;
        n_short   = n_d < r_lower;
        n_out     = n_long || n_short;
        n_full    = (r_logged >= CW'(LOG_DEPTH));
        n_wr_addr = r_logged[AW-1:0];
        n_rem_sh  = {r_rem[31:0], r_quot[63]};
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) r_in <= i_in;
        // read the log when the beat is taken; address checked against fill count
        if (i_in_fire) begin
            r_rd_seq  <= r_mem_seq[i_in.log_slot[AW-1:0]];
            r_rd_ival <= r_mem_ival[i_in.log_slot[AW-1:0]];
            r_rd_time <= r_mem_time[i_in.log_slot[AW-1:0]];
            r_rd_ok   <= ({1'b0, i_in.log_slot} < 5'(r_logged)) &&
                         (32'(i_in.log_slot) < 32'(LOG_DEPTH));
        end
        if (i_ctrl.exec && r_in.command == tijm_pkg::CMD_NOTE_TX && !n_prime && !n_back
            && n_out && !n_full) begin
            r_mem_seq[n_wr_addr]  <= r_in.seq_num;
            r_mem_ival[n_wr_addr] <= n_d;
            r_mem_time[n_wr_addr] <= r_in.timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper      <= '1;
            r_lower      <= '0;
            r_prev_time  <= '0;
            r_pkt_cnt    <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_sum        <= '0;
            r_samples    <= '0;
            r_latest_seq <= '0;
            r_start_seq  <= '0;
            r_snap_avg   <= '0;
            r_snap_pkts  <= '0;
            r_snap_span  <= '0;
            r_snap_first <= '0;
            r_logged     <= '0;
            r_status     <= tijm_pkg::ST_NONE;
            r_ival       <= '0;
            r_quot       <= '0;
            r_rem        <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == tijm_pkg::REG_UPPER) r_upper <= i_cfg_data;
                else if (i_cfg_idx == tijm_pkg::REG_LOWER) r_lower <= i_cfg_data;
            end
            if (i_ctrl.exec) begin
                r_status <= tijm_pkg::ST_NONE;
                r_ival   <= '0;
                case (r_in.command)
                    tijm_pkg::CMD_NOTE_TX: begin
                        r_pkt_cnt    <= n_pkt_cnt;
                        r_latest_seq <= r_in.seq_num;
                        if (n_prime) begin
                            r_prev_time <= r_in.timestamp;
                            r_status    <= tijm_pkg::ST_PRIMED;
                        end else if (n_back) begin
                            r_prev_time <= r_in.timestamp;
                            r_status    <= tijm_pkg::ST_BACKWARDS;
                        end else begin
                            r_ival <= n_d;
                            if (r_max == '0 || n_d > r_max) r_max <= n_d;
                            if (r_min == '0 || n_d < r_min) r_min <= n_d;
                            r_sum     <= r_sum + {32'd0, n_d};
                            r_samples <= r_samples + 32'd1;
                            if (n_out && n_full) begin
                                r_status <= tijm_pkg::ST_LOG_FULL;
                            end else begin
                                r_prev_time <= r_in.timestamp;
                                if (n_out) r_logged <= r_logged + CW'(1);
                                r_status <= n_long ? tijm_pkg::ST_TOO_LONG :
                                            n_short ? tijm_pkg::ST_TOO_SHORT :
                                            tijm_pkg::ST_IN_RANGE;
                            end
                        end
                    end
                    tijm_pkg::CMD_RESET_MEAS: begin
                        r_min        <= '0;
                        r_max        <= '0;
                        r_sum        <= '0;
                        r_samples    <= '0;
                        r_logged     <= '0;
                        r_latest_seq <= '0;
                        r_snap_avg   <= '0;
                        r_snap_pkts  <= '0;
                        r_snap_span  <= '0;
                        r_snap_first <= r_start_seq;
                    end
                    default: ;
                endcase
            end
            if (i_ctrl.div_start) begin
                r_status <= tijm_pkg::ST_NONE;
                r_ival   <= '0;
                r_quot   <= r_sum;
                r_rem    <= '0;
            end
            if (i_ctrl.div_step) begin
                // restoring step: one quotient bit per cycle
                if (n_rem_sh >= {1'b0, r_samples}) begin
                    r_rem  <= n_rem_sh - {1'b0, r_samples};
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= n_rem_sh;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
            end
            if (i_ctrl.div_done) begin
                r_snap_avg   <= (r_samples == '0) ? 32'd0 : r_quot[31:0];
                r_snap_first <= r_start_seq;
                r_snap_span  <= r_latest_seq - r_start_seq;
                r_start_seq  <= r_latest_seq;
                r_snap_pkts  <= r_pkt_cnt;
                r_pkt_cnt    <= '0;
            end
        end
    end

    logic n_show_log;
    assign n_show_log = (r_in.command == tijm_pkg::CMD_READ_LOG) && r_rd_ok;

    always_comb begin
        o_out.status                = r_status;
        o_out.interval              = r_ival;
        o_out.min_interval          = r_min;
        o_out.max_interval          = r_max;
        o_out.average_interval      = r_snap_avg;
        o_out.packets_in_period     = r_snap_pkts;
        o_out.window_first_sequence = r_snap_first;
        o_out.window_sequence_span  = r_snap_span;
        o_out.violation_count       = 5'(r_logged);
        o_out.log_sequence          = n_show_log ? r_rd_seq  : '0;
        o_out.log_interval          = n_show_log ? r_rd_ival : '0;
        o_out.log_time              = n_show_log ? r_rd_time : '0;
    end
endmodule

// ===== src/tx_interval_jitter_monitor_core.sv =====
// Top level: transmit interval jitter monitor.
//
//  channel | dir | payload            | beat
//  in_ch   | in  | t_in_item          | valid & ready
//  out_ch  | out | t_out_item         | valid & ready
//  cfg     | in  | idx, 32-bit data   | i_cfg_we
//
// note_tx, reset_measurement, read_log: registered through exec and out.
// end_of_period: exec, the one-bit-per-cycle 64-by-32 divider, then out.
// One item at a time; a new beat is taken only once the result has gone.
// Reset is synchronous, active low; the log holds no reset and is read only
// below the fill count.
module tx_interval_jitter_monitor_core #(
    parameter int LOG_DEPTH = tijm_pkg::LOG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tijm_stream_if.sink                     in_ch,
    tijm_stream_if.source                   out_ch,
    input  logic                            i_cfg_we,
    input  logic [tijm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tijm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    tijm_pkg::t_ctrl ctrl;
    tijm_pkg::t_stat stat;
    logic in_ready;

    assign in_ch.ready = in_ready;

    tijm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    tijm_datapath #(.LOG_DEPTH(LOG_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_ch.valid && in_ready),
        .i_in       (in_ch.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .o_out      (out_ch.data)
    );
endmodule

// ===== src/tijm_checker.sv =====
// Checker: port-level properties of the monitor, bound to the top level.
module tijm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tijm_pkg::t_out_item i_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result dropped under stall");
    a_no_take_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("beat taken while result pending");
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid && !i_in_ready)
        else $error("result too early");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.violation_count <= 5'd16 && i_out.status <= 3'd6)
        else $error("result field out of range");
endmodule

bind tx_interval_jitter_monitor_core tijm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_out       (out_ch.data)
);
